// ----- hdl/dual_packet_queue_with_serial_flush_defines.svh -----
// Assertion macros for the dual packet queue.
// Clock and reset are taken from the including module (clock, reset).
`ifndef DUAL_PACKET_QUEUE_WITH_SERIAL_FLUSH_DEFINES_SVH
`define DUAL_PACKET_QUEUE_WITH_SERIAL_FLUSH_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define DPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define DPQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define DPQ_ASSERT(lbl, prop, msg)
`define DPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/dpq_pkg.sv -----
// Shared types and constants of the dual packet queue.
// No dependencies; imported by the top level.
package dpq_pkg;

   localparam int DEPTH         = 32;
   localparam int HANDLE_BITS   = 32;
   localparam int SERIAL_BITS   = 16;
   localparam int POS_BITS      = $clog2(DEPTH);
   localparam int LEVEL_BITS    = POS_BITS + 1;
   localparam int ENTRY_BITS    = HANDLE_BITS + SERIAL_BITS;
   localparam int STREAM_BITS   = 8;
   localparam int CAP_BITS      = 6;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [STREAM_BITS-1:0] VIDEO_ID_AT_RESET = 8'd0;
   localparam logic [STREAM_BITS-1:0] AUDIO_ID_AT_RESET = 8'd1;
   localparam logic [CAP_BITS-1:0]    CAP_AT_RESET      = 6'd30;

   localparam logic [1:0] REG_VIDEO_ID = 2'd0;
   localparam logic [1:0] REG_AUDIO_ID = 2'd1;
   localparam logic [1:0] REG_CAPACITY = 2'd2;

   typedef enum logic [1:0] {
      OP_ARRIVAL   = 2'd0,
      OP_POP_AUDIO = 2'd1,
      OP_POP_VIDEO = 2'd2,
      OP_SEEK      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_QUEUED_VIDEO = 3'd0,
      ST_QUEUED_AUDIO = 3'd1,
      ST_DROPPED      = 3'd2,
      ST_REFUSED      = 3'd3,
      ST_DELIVERED    = 3'd4,
      ST_EMPTY        = 3'd5,
      ST_MISMATCH     = 3'd6,
      ST_FLUSHED      = 3'd7
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  stream_num;
      logic [31:0] packet_handle;
      logic [15:0] consumer_serial;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] out_packet_handle;
      logic [15:0] out_serial;
      logic [5:0]  audio_fill_out;
      logic [5:0]  video_fill_out;
   } rsp_type;

endpackage

// ----- hdl/dpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for each packet queue.
module dpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the contents before a write at the same edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dual_packet_queue_with_serial_flush.sv -----
// Dual packet queue (audio and video rings) with generation serial and seek flush.
// A transaction is taken into the input register and its result into the result
// register. Throughput: one transaction per cycle while the response does not stall,
// set by the single execute stage and the registered, pointer-tracking entry RAM reads.
// Reset: synchronous, active high; clears pointers, levels, generations, valid flags
// and loads the register reset values. Entry RAMs are not cleared (no clearing pass).
module dual_packet_queue_with_serial_flush (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dpq_pkg::req_type                 req_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dpq_pkg::rsp_type                 rsp_data,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dpq_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dpq_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dpq_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                             csr_pready
);

   import dpq_pkg::*;

   `include "dual_packet_queue_with_serial_flush_defines.svh"

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [STREAM_BITS-1:0] video_id_ff;
   logic [STREAM_BITS-1:0] audio_id_ff;
   logic [CAP_BITS-1:0]    capacity_ff;
   logic                   csr_write;
   logic [1:0]             csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         video_id_ff <= VIDEO_ID_AT_RESET;
         audio_id_ff <= AUDIO_ID_AT_RESET;
         capacity_ff <= CAP_AT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_VIDEO_ID: video_id_ff <= csr_pwdata[STREAM_BITS-1:0];
            REG_AUDIO_ID: audio_id_ff <= csr_pwdata[STREAM_BITS-1:0];
            REG_CAPACITY: capacity_ff <= csr_pwdata[CAP_BITS-1:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   // Return the addressed register; unmapped addresses read zero.
   always_comb begin
      unique case (csr_index)
         REG_VIDEO_ID: csr_prdata = CSR_DATA_BITS'(video_id_ff);
         REG_AUDIO_ID: csr_prdata = CSR_DATA_BITS'(audio_id_ff);
         REG_CAPACITY: csr_prdata = CSR_DATA_BITS'(capacity_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Saturate the capacity to the range one to DEPTH.
   logic [LEVEL_BITS-1:0] cap_eff;
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = LEVEL_BITS'(1);
      end else if (LEVEL_BITS'(capacity_ff) > LEVEL_BITS'(DEPTH)) begin
         cap_eff = LEVEL_BITS'(DEPTH);
      end else begin
         cap_eff = LEVEL_BITS'(capacity_ff);
      end
   end

   // Step a ring position; wrap to zero at or past the capacity.
   function automatic logic [POS_BITS-1:0] pos_advance(
      input logic [POS_BITS-1:0]   pos,
      input logic [LEVEL_BITS-1:0] cap
   );
      logic [LEVEL_BITS-1:0] nx;
      nx = LEVEL_BITS'(pos) + LEVEL_BITS'(1);
      return (nx >= cap) ? '0 : nx[POS_BITS-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Input register and result register
   // ------------------------------------------------------------------
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    execute;

   // Execute the held transaction whenever the result register is free or
   // is being emptied in this cycle. Hold the input only behind a stalled result.
   assign execute   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && rsp_valid_ff && rsp_stall;

   always_comb begin
      if (execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Queue state
   // ------------------------------------------------------------------
   logic [POS_BITS-1:0]    audio_wr_pos_ff, audio_wr_pos_in;
   logic [POS_BITS-1:0]    audio_rd_pos_ff, audio_rd_pos_in;
   logic [LEVEL_BITS-1:0]  audio_level_ff, audio_level_in;
   logic [SERIAL_BITS-1:0] audio_gen_ff, audio_gen_in;
   logic [POS_BITS-1:0]    video_wr_pos_ff, video_wr_pos_in;
   logic [POS_BITS-1:0]    video_rd_pos_ff, video_rd_pos_in;
   logic [LEVEL_BITS-1:0]  video_level_ff, video_level_in;
   logic [SERIAL_BITS-1:0] video_gen_ff, video_gen_in;

   // Entry RAM ports. Each RAM reads at the next read position every cycle,
   // so with the bypass below its output shows the current head.
   logic                  audio_we, video_we;
   logic [ENTRY_BITS-1:0] audio_wdata, video_wdata;
   logic [ENTRY_BITS-1:0] audio_rdata, video_rdata;
   logic [ENTRY_BITS-1:0] audio_head, video_head;

   // Forward a write that landed on the head slot at the previous edge:
   // the RAM read at that edge still saw the old contents.
   logic                  audio_byp_ff, audio_byp_in;
   logic                  video_byp_ff, video_byp_in;
   logic [ENTRY_BITS-1:0] audio_byp_data_ff, video_byp_data_ff;

   assign audio_head = audio_byp_ff ? audio_byp_data_ff : audio_rdata;
   assign video_head = video_byp_ff ? video_byp_data_ff : video_rdata;

   assign audio_wdata = {audio_gen_ff, req_ff.packet_handle[HANDLE_BITS-1:0]};
   assign video_wdata = {video_gen_ff, req_ff.packet_handle[HANDLE_BITS-1:0]};

   assign audio_byp_in = audio_we && (audio_wr_pos_ff == audio_rd_pos_in);
   assign video_byp_in = video_we && (video_wr_pos_ff == video_rd_pos_in);

   dpq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_audio_ram (
      .clock   (clock),
      .wr_en   (audio_we),
      .wr_addr (audio_wr_pos_ff),
      .wr_data (audio_wdata),
      .rd_addr (audio_rd_pos_in),
      .rd_data (audio_rdata)
   );

   dpq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_video_ram (
      .clock   (clock),
      .wr_en   (video_we),
      .wr_addr (video_wr_pos_ff),
      .wr_data (video_wdata),
      .rd_addr (video_rd_pos_in),
      .rd_data (video_rdata)
   );

   // ------------------------------------------------------------------
   // Execute stage
   // ------------------------------------------------------------------
   logic [SERIAL_BITS-1:0] cons_serial;
   logic                   any_full;

   assign cons_serial = req_ff.consumer_serial[SERIAL_BITS-1:0];
   // Refuse every arrival while either queue sits at capacity.
   assign any_full    = (audio_level_ff >= cap_eff) || (video_level_ff >= cap_eff);

   always_comb begin
      audio_wr_pos_in = audio_wr_pos_ff;
      audio_rd_pos_in = audio_rd_pos_ff;
      audio_level_in  = audio_level_ff;
      audio_gen_in    = audio_gen_ff;
      video_wr_pos_in = video_wr_pos_ff;
      video_rd_pos_in = video_rd_pos_ff;
      video_level_in  = video_level_ff;
      video_gen_in    = video_gen_ff;
      audio_we        = 1'b0;
      video_we        = 1'b0;

      rsp_in.status            = ST_DROPPED;
      rsp_in.out_packet_handle = '0;
      rsp_in.out_serial        = 16'(cons_serial);

      if (req_valid_ff) begin
         unique case (req_ff.op)
            OP_ARRIVAL: begin
               // Video wins when both ids match.
               if (any_full) begin
                  rsp_in.status = ST_REFUSED;
               end else if (req_ff.stream_num == video_id_ff) begin
                  video_we        = execute;
                  video_wr_pos_in = pos_advance(video_wr_pos_ff, cap_eff);
                  video_level_in  = video_level_ff + LEVEL_BITS'(1);
                  rsp_in.status   = ST_QUEUED_VIDEO;
               end else if (req_ff.stream_num == audio_id_ff) begin
                  audio_we        = execute;
                  audio_wr_pos_in = pos_advance(audio_wr_pos_ff, cap_eff);
                  audio_level_in  = audio_level_ff + LEVEL_BITS'(1);
                  rsp_in.status   = ST_QUEUED_AUDIO;
               end else begin
                  rsp_in.status = ST_DROPPED;
               end
            end
            OP_POP_AUDIO: begin
               if (audio_level_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_in.out_serial = 16'(audio_head[ENTRY_BITS-1:HANDLE_BITS]);
                  if (audio_gen_ff != cons_serial) begin
                     rsp_in.status = ST_MISMATCH;
                  end else begin
                     rsp_in.status            = ST_DELIVERED;
                     rsp_in.out_packet_handle = 32'(audio_head[HANDLE_BITS-1:0]);
                     audio_rd_pos_in = pos_advance(audio_rd_pos_ff, cap_eff);
                     audio_level_in  = audio_level_ff - LEVEL_BITS'(1);
                  end
               end
            end
            OP_POP_VIDEO: begin
               if (video_level_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_in.out_serial = 16'(video_head[ENTRY_BITS-1:HANDLE_BITS]);
                  if (video_gen_ff != cons_serial) begin
                     rsp_in.status = ST_MISMATCH;
                  end else begin
                     rsp_in.status            = ST_DELIVERED;
                     rsp_in.out_packet_handle = 32'(video_head[HANDLE_BITS-1:0]);
                     video_rd_pos_in = pos_advance(video_rd_pos_ff, cap_eff);
                     video_level_in  = video_level_ff - LEVEL_BITS'(1);
                  end
               end
            end
            OP_SEEK: begin
               // Empty both rings and move both generations on.
               audio_rd_pos_in = audio_wr_pos_ff;
               audio_level_in  = '0;
               audio_gen_in    = audio_gen_ff + SERIAL_BITS'(1);
               video_rd_pos_in = video_wr_pos_ff;
               video_level_in  = '0;
               video_gen_in    = video_gen_ff + SERIAL_BITS'(1);
               rsp_in.status   = ST_FLUSHED;
            end
            default: ;
         endcase
      end

      // Leave state untouched unless the transaction really executes.
      if (!execute) begin
         audio_wr_pos_in = audio_wr_pos_ff;
         audio_rd_pos_in = audio_rd_pos_ff;
         audio_level_in  = audio_level_ff;
         audio_gen_in    = audio_gen_ff;
         video_wr_pos_in = video_wr_pos_ff;
         video_rd_pos_in = video_rd_pos_ff;
         video_level_in  = video_level_ff;
         video_gen_in    = video_gen_ff;
      end

      rsp_in.audio_fill_out = 6'(audio_level_in);
      rsp_in.video_fill_out = 6'(video_level_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_wr_pos_ff <= '0;
         audio_rd_pos_ff <= '0;
         audio_level_ff  <= '0;
         audio_gen_ff    <= '0;
         video_wr_pos_ff <= '0;
         video_rd_pos_ff <= '0;
         video_level_ff  <= '0;
         video_gen_ff    <= '0;
         audio_byp_ff    <= 1'b0;
         video_byp_ff    <= 1'b0;
      end else begin
         audio_wr_pos_ff <= audio_wr_pos_in;
         audio_rd_pos_ff <= audio_rd_pos_in;
         audio_level_ff  <= audio_level_in;
         audio_gen_ff    <= audio_gen_in;
         video_wr_pos_ff <= video_wr_pos_in;
         video_rd_pos_ff <= video_rd_pos_in;
         video_level_ff  <= video_level_in;
         video_gen_ff    <= video_gen_in;
         audio_byp_ff    <= audio_byp_in;
         video_byp_ff    <= video_byp_in;
      end
      audio_byp_data_ff <= audio_wdata;
      video_byp_data_ff <= video_wdata;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A flush result reports both queues empty.
   `DPQ_ASSERT(a_flush_empties,
      rsp_valid_ff && (rsp_ff.status == ST_FLUSHED) |->
         (rsp_ff.audio_fill_out == '0) && (rsp_ff.video_fill_out == '0),
      "flush result with nonzero fill")

   // Only a delivery carries a packet handle.
   `DPQ_ASSERT(a_handle_only_on_delivery,
      rsp_valid_ff && (rsp_ff.status != ST_DELIVERED) |->
         (rsp_ff.out_packet_handle == '0),
      "nonzero handle without delivery")

   // Levels move by at most one per cycle, or drop to zero on a flush.
   `DPQ_ASSERT(a_level_step,
      1'b1 |=>
         ((audio_level_ff == $past(audio_level_ff)) ||
          (audio_level_ff == $past(audio_level_ff) + 1'b1) ||
          (audio_level_ff == $past(audio_level_ff) - 1'b1) ||
          (audio_level_ff == '0)) &&
         ((video_level_ff == $past(video_level_ff)) ||
          (video_level_ff == $past(video_level_ff) + 1'b1) ||
          (video_level_ff == $past(video_level_ff) - 1'b1) ||
          (video_level_ff == '0)),
      "queue level jumped")

endmodule
